/* rtl/i2cms_pkg.sv */
// shared types and constants for the i2c master transfer sequencer
// no dependencies; used by the response interface, the step logic, the top level and the bench
package i2cms_pkg;

   localparam int LENGTH_BITS  = 16;
   localparam int TIMEOUT_BITS = 32;

   // default wait budget, saturated to the timeout counter width
   localparam logic [TIMEOUT_BITS-1:0] DEFAULT_WAIT =
      (TIMEOUT_BITS >= 16) ? TIMEOUT_BITS'(17'h0FFFF) : '1;

   // controller status codes
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_REP_START  = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
   localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
   localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_IRQ   = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_START     = 3'd1,
      PH_SLA_W     = 3'd2,
      PH_DATA_W    = 3'd3,
      PH_REP_START = 3'd4,
      PH_SLA_R     = 3'd5,
      PH_DATA_R    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_LOAD  = 3'd2,
      ACT_ACK   = 3'd3,
      ACT_NACK  = 3'd4,
      ACT_STOP  = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      RC_OK      = 3'd0,
      RC_UNSUP   = 3'd1,
      RC_PARAM   = 3'd2,
      RC_BUSY    = 3'd3,
      RC_ERROR   = 3'd4,
      RC_TIMEOUT = 3'd5
   } result_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_TX_DONE = 2'd1,
      EV_RX_DONE = 2'd2
   } event_type;

   typedef enum logic [0:0] {
      CSR_MASTER_ROLE  = 1'd0,
      CSR_EVENT_ENABLE = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic master_role;
      logic event_enable;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [6:0]  slave_address;
      logic [15:0] write_length;
      logic [15:0] read_length;
      logic [31:0] wait_limit;
      logic [7:0]  bus_status;
      logic [7:0]  received_byte;
      logic [7:0]  next_tx_byte;
   } req_type;

   typedef struct packed {
      action_type action;
      logic [7:0] byte_to_send;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       done_res;
      result_type result_code;
      event_type  completion_event;
   } rsp_type;

   typedef struct packed {
      phase_type               phase;
      logic [6:0]              target_address;
      logic [LENGTH_BITS-1:0]  tx_left;
      logic [LENGTH_BITS-1:0]  rx_left;
      logic [TIMEOUT_BITS-1:0] timeout_reload;
      logic [TIMEOUT_BITS-1:0] wait_count;
      logic                    saw_read;
   } state_type;

endpackage

/* rtl/i2cms_req_if.sv */
// request channel: valid/ready handshake carrying one command beat
// depends on nothing; its field widths match req_type in i2cms_pkg
interface i2cms_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [6:0]  slave_address;
   logic [15:0] write_length;
   logic [15:0] read_length;
   logic [31:0] wait_limit;
   logic [7:0]  bus_status;
   logic [7:0]  received_byte;
   logic [7:0]  next_tx_byte;

   modport source (output valid, command, slave_address, write_length, read_length,
                   wait_limit, bus_status, received_byte, next_tx_byte,
                   input ready);
   modport sink (input valid, command, slave_address, write_length, read_length,
                 wait_limit, bus_status, received_byte, next_tx_byte,
                 output ready);
endinterface

/* rtl/i2cms_rsp_if.sv */
// response channel: valid/ready handshake carrying one result beat
// depends on i2cms_pkg for the field types
interface i2cms_rsp_if;
   logic                    valid;
   logic                    ready;
   i2cms_pkg::action_type   action;
   logic [7:0]              byte_to_send;
   logic                    rx_valid;
   logic [7:0]              rx_data;
   logic                    done_res;
   i2cms_pkg::result_type   result_code;
   i2cms_pkg::event_type    completion_event;

   modport source (output valid, action, byte_to_send, rx_valid, rx_data, done_res,
                   result_code, completion_event, input ready);
   modport sink (input valid, action, byte_to_send, rx_valid, rx_data, done_res,
                 result_code, completion_event, output ready);
endinterface

/* rtl/i2cms_step.sv */
// next-state and result logic for one command beat of the transfer sequencer
// depends on i2cms_pkg
module i2cms_step (
   input  i2cms_pkg::cfg_type   cfg,
   input  i2cms_pkg::state_type cur,
   input  i2cms_pkg::req_type   req,
   output i2cms_pkg::state_type nxt,
   output i2cms_pkg::rsp_type   res
);

   logic [i2cms_pkg::LENGTH_BITS-1:0]  wl;
   logic [i2cms_pkg::LENGTH_BITS-1:0]  rl;
   logic [i2cms_pkg::LENGTH_BITS-1:0]  rx_dec;
   logic [i2cms_pkg::TIMEOUT_BITS-1:0] lim;
   logic [i2cms_pkg::TIMEOUT_BITS-1:0] cnt_dec;
   logic [7:0]                         sla_w;
   logic [7:0]                         sla_r;
   logic                               fin;
   logic                               fin_event;
   i2cms_pkg::result_type              fin_code;

   assign wl      = req.write_length[i2cms_pkg::LENGTH_BITS-1:0];
   assign rl      = req.read_length[i2cms_pkg::LENGTH_BITS-1:0];
   assign lim     = req.wait_limit[i2cms_pkg::TIMEOUT_BITS-1:0];
   assign cnt_dec = cur.wait_count - 1'b1;
   assign rx_dec  = (cur.rx_left != '0) ? cur.rx_left - 1'b1 : cur.rx_left;
   assign sla_w   = {cur.target_address, 1'b0};
   assign sla_r   = {cur.target_address, 1'b1};

   always_comb begin
      nxt       = cur;
      res       = '0;
      fin       = 1'b0;
      fin_event = 1'b0;
      fin_code  = i2cms_pkg::RC_OK;

      if (i2cms_pkg::command_type'(req.command) == i2cms_pkg::CMD_START) begin
         res.done_res = 1'b1;
         if (!cfg.master_role) begin
            res.result_code = i2cms_pkg::RC_UNSUP;
         end else if (wl == '0 && rl == '0) begin
            res.result_code = i2cms_pkg::RC_PARAM;
         end else if (cur.phase != i2cms_pkg::PH_IDLE) begin
            res.result_code = i2cms_pkg::RC_BUSY;
         end else begin
            res.done_res       = 1'b0;
            res.action         = i2cms_pkg::ACT_START;
            nxt.target_address = req.slave_address;
            nxt.tx_left        = wl;
            nxt.rx_left        = rl;
            nxt.saw_read       = (rl != '0);
            nxt.timeout_reload = (lim == '0) ? i2cms_pkg::DEFAULT_WAIT : lim;
            nxt.wait_count     = nxt.timeout_reload;
            nxt.phase          = i2cms_pkg::PH_START;
         end
      end else if (cur.phase != i2cms_pkg::PH_IDLE &&
                   i2cms_pkg::command_type'(req.command) == i2cms_pkg::CMD_TICK) begin
         nxt.wait_count = cnt_dec;
         if (cnt_dec == '0) begin
            fin      = 1'b1;
            fin_code = (cur.phase == i2cms_pkg::PH_START ||
                        cur.phase == i2cms_pkg::PH_REP_START) ?
                       i2cms_pkg::RC_ERROR : i2cms_pkg::RC_TIMEOUT;
         end
      end else if (i2cms_pkg::command_type'(req.command) == i2cms_pkg::CMD_IRQ) begin
         unique case (cur.phase)
            i2cms_pkg::PH_IDLE: begin
            end
            i2cms_pkg::PH_START: begin
               if (req.bus_status != i2cms_pkg::ST_START) begin
                  fin      = 1'b1;
                  fin_code = i2cms_pkg::RC_ERROR;
               end else begin
                  res.action     = i2cms_pkg::ACT_LOAD;
                  nxt.wait_count = cur.timeout_reload;
                  if (cur.tx_left != '0) begin
                     res.byte_to_send = sla_w;
                     nxt.phase        = i2cms_pkg::PH_SLA_W;
                  end else begin
                     res.byte_to_send = sla_r;
                     nxt.phase        = i2cms_pkg::PH_SLA_R;
                  end
               end
            end
            i2cms_pkg::PH_SLA_W, i2cms_pkg::PH_DATA_W: begin
               if (req.bus_status != ((cur.phase == i2cms_pkg::PH_SLA_W) ?
                                      i2cms_pkg::ST_SLA_W_ACK :
                                      i2cms_pkg::ST_DATA_W_ACK)) begin
                  fin      = 1'b1;
                  fin_code = i2cms_pkg::RC_ERROR;
               end else if (cur.tx_left != '0) begin
                  res.action       = i2cms_pkg::ACT_LOAD;
                  res.byte_to_send = req.next_tx_byte;
                  nxt.tx_left      = cur.tx_left - 1'b1;
                  nxt.wait_count   = cur.timeout_reload;
                  nxt.phase        = i2cms_pkg::PH_DATA_W;
               end else if (cur.rx_left != '0) begin
                  res.action     = i2cms_pkg::ACT_START;
                  nxt.wait_count = cur.timeout_reload;
                  nxt.phase      = i2cms_pkg::PH_REP_START;
               end else begin
                  fin       = 1'b1;
                  fin_event = 1'b1;
               end
            end
            i2cms_pkg::PH_REP_START: begin
               if (req.bus_status != i2cms_pkg::ST_REP_START) begin
                  fin      = 1'b1;
                  fin_code = i2cms_pkg::RC_ERROR;
               end else begin
                  res.action       = i2cms_pkg::ACT_LOAD;
                  res.byte_to_send = sla_r;
                  nxt.wait_count   = cur.timeout_reload;
                  nxt.phase        = i2cms_pkg::PH_SLA_R;
               end
            end
            i2cms_pkg::PH_SLA_R: begin
               if (req.bus_status != i2cms_pkg::ST_SLA_R_ACK) begin
                  fin      = 1'b1;
                  fin_code = i2cms_pkg::RC_ERROR;
               end else begin
                  res.action     = (cur.rx_left > 1) ? i2cms_pkg::ACT_ACK :
                                                       i2cms_pkg::ACT_NACK;
                  nxt.wait_count = cur.timeout_reload;
                  nxt.phase      = i2cms_pkg::PH_DATA_R;
               end
            end
            i2cms_pkg::PH_DATA_R: begin
               // read data status is not checked
               res.rx_valid = 1'b1;
               res.rx_data  = req.received_byte;
               nxt.rx_left  = rx_dec;
               if (rx_dec != '0) begin
                  res.action     = (rx_dec > 1) ? i2cms_pkg::ACT_ACK :
                                                  i2cms_pkg::ACT_NACK;
                  nxt.wait_count = cur.timeout_reload;
                  nxt.phase      = i2cms_pkg::PH_DATA_R;
               end else begin
                  fin       = 1'b1;
                  fin_event = 1'b1;
               end
            end
            default: begin
               nxt.phase = i2cms_pkg::PH_IDLE;
            end
         endcase
      end

      if (fin) begin
         res.action      = i2cms_pkg::ACT_STOP;
         res.done_res    = 1'b1;
         res.result_code = fin_code;
         nxt.phase       = i2cms_pkg::PH_IDLE;
         nxt.wait_count  = '0;
         if (fin_event && cfg.event_enable) begin
            res.completion_event = cur.saw_read ? i2cms_pkg::EV_RX_DONE :
                                                  i2cms_pkg::EV_TX_DONE;
         end
      end
   end

endmodule

/* rtl/i2c_master_transfer_sequencer.sv */
// i2c master write-then-read transfer sequencer, one result beat per command beat
// a command beat passes the input register, then the result register, and waits there while
// the result side stalls; throughput: one beat per cycle when the result side is not stalled,
// set by the combinational next-state logic in i2cms_step
// reset (synchronous, active high) returns to idle, master_role 1, event_enable 0,
// wait reload 65535; depends on i2cms_pkg, i2cms_req_if, i2cms_rsp_if, i2cms_step
module i2c_master_transfer_sequencer (
   input  logic               clock,
   input  logic               reset,
   i2cms_req_if.sink          req_ch,
   i2cms_rsp_if.source        rsp_ch,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [0:0]         csr_wdata
);

   i2cms_pkg::cfg_type   cfg_ff, cfg_in;
   i2cms_pkg::state_type state_ff, state_next;
   i2cms_pkg::req_type   item_ff, item_in;
   i2cms_pkg::rsp_type   res_ff, res_next;
   logic                 item_vld_ff, item_vld_in;
   logic                 res_vld_ff, res_vld_in;
   logic                 advance;
   logic                 req_take;

   // result register frees up when empty or being taken
   assign advance    = !res_vld_ff || rsp_ch.ready;
   assign req_ch.ready = !item_vld_ff || advance;
   assign req_take   = req_ch.valid && req_ch.ready;

   assign item_in = '{command:       req_ch.command,
                      slave_address: req_ch.slave_address,
                      write_length:  req_ch.write_length,
                      read_length:   req_ch.read_length,
                      wait_limit:    req_ch.wait_limit,
                      bus_status:    req_ch.bus_status,
                      received_byte: req_ch.received_byte,
                      next_tx_byte:  req_ch.next_tx_byte};

   assign item_vld_in = req_take || (item_vld_ff && !advance);
   assign res_vld_in  = (item_vld_ff && advance) || (res_vld_ff && !rsp_ch.ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (i2cms_pkg::csr_index_type'(csr_index))
            i2cms_pkg::CSR_MASTER_ROLE:  cfg_in.master_role  = csr_wdata[0];
            i2cms_pkg::CSR_EVENT_ENABLE: cfg_in.event_enable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   i2cms_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (item_ff),
      .nxt (state_next),
      .res (res_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '{master_role: 1'b1, event_enable: 1'b0};
         item_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
         state_ff    <= '{phase:          i2cms_pkg::PH_IDLE,
                          target_address: '0,
                          tx_left:        '0,
                          rx_left:        '0,
                          timeout_reload: i2cms_pkg::DEFAULT_WAIT,
                          wait_count:     '0,
                          saw_read:       1'b0};
      end else begin
         cfg_ff      <= cfg_in;
         item_vld_ff <= item_vld_in;
         res_vld_ff  <= res_vld_in;
         if (item_vld_ff && advance) begin
            state_ff <= state_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (item_vld_ff && advance) begin
         res_ff <= res_next;
      end
   end

   assign rsp_ch.valid            = res_vld_ff;
   assign rsp_ch.action           = res_ff.action;
   assign rsp_ch.byte_to_send     = res_ff.byte_to_send;
   assign rsp_ch.rx_valid         = res_ff.rx_valid;
   assign rsp_ch.rx_data          = res_ff.rx_data;
   assign rsp_ch.done_res         = res_ff.done_res;
   assign rsp_ch.result_code      = res_ff.result_code;
   assign rsp_ch.completion_event = res_ff.completion_event;

endmodule

/* bench/i2cms_sequence_monitor.sv */
// watches the request, result and csr ports of the i2c transfer sequencer, predicts every
// result beat and compares it with what the block returns
// depends on i2cms_pkg, i2cms_req_if and i2cms_rsp_if
module i2cms_sequence_monitor
   import i2cms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   i2cms_req_if       req_mon,
   i2cms_rsp_if       rsp_mon,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [0:0] csr_wdata,
   output int         fail_count,
   output int         pending,
   output int         checked
);

   // predicted sequencer state and configuration
   logic                    m_master;
   logic                    m_events;
   phase_type               m_phase;
   logic [6:0]              m_addr;
   logic [LENGTH_BITS-1:0]  m_tx_left;
   logic [LENGTH_BITS-1:0]  m_rx_left;
   logic [TIMEOUT_BITS-1:0] m_reload;
   logic [TIMEOUT_BITS-1:0] m_count;
   logic                    m_saw_read;

   rsp_type steps_due [$];
   req_type cmd_beat;
   rsp_type want;
   rsp_type seen;
   int      errors;
   int      reported;
   int      results;

   function automatic void clear_model();
      m_master   = 1'b1;
      m_events   = 1'b0;
      m_phase    = PH_IDLE;
      m_addr     = '0;
      m_tx_left  = '0;
      m_rx_left  = '0;
      m_reload   = DEFAULT_WAIT;
      m_count    = '0;
      m_saw_read = 1'b0;
   endfunction

   function automatic void reload_wait(input phase_type next);
      m_phase = next;
      m_count = m_reload;
   endfunction

   function automatic void stop_transfer(inout rsp_type o, input result_type code);
      o.action      = ACT_STOP;
      o.done_res    = 1'b1;
      o.result_code = code;
      m_phase       = PH_IDLE;
      m_count       = '0;
   endfunction

   function automatic void finish_ok(inout rsp_type o);
      stop_transfer(o, RC_OK);
      if (m_events) begin
         o.completion_event = m_saw_read ? EV_RX_DONE : EV_TX_DONE;
      end
   endfunction

   // one command beat in, the bus step it causes out
   function automatic rsp_type sequence_step(input req_type b);
      rsp_type    o;
      logic [7:0] ack_code;
      o = '0;
      if (b.command == CMD_START) begin
         if (!m_master) begin
            o.done_res    = 1'b1;
            o.result_code = RC_UNSUP;
         end else if (b.write_length == '0 && b.read_length == '0) begin
            o.done_res    = 1'b1;
            o.result_code = RC_PARAM;
         end else if (m_phase != PH_IDLE) begin
            o.done_res    = 1'b1;
            o.result_code = RC_BUSY;
         end else begin
            m_addr     = b.slave_address;
            m_tx_left  = b.write_length;
            m_rx_left  = b.read_length;
            m_saw_read = (b.read_length != '0);
            m_reload   = (b.wait_limit == '0) ? DEFAULT_WAIT : b.wait_limit;
            reload_wait(PH_START);
            o.action = ACT_START;
         end
      end else if (m_phase != PH_IDLE && b.command != CMD_NOP) begin
         if (b.command == CMD_TICK) begin
            m_count = m_count - 1'b1;
            if (m_count == '0) begin
               stop_transfer(o, (m_phase == PH_START || m_phase == PH_REP_START) ?
                             RC_ERROR : RC_TIMEOUT);
            end
         end else begin
            case (m_phase)
               PH_START: begin
                  if (b.bus_status != ST_START) begin
                     stop_transfer(o, RC_ERROR);
                  end else begin
                     o.action = ACT_LOAD;
                     if (m_tx_left != '0) begin
                        o.byte_to_send = {m_addr, 1'b0};
                        reload_wait(PH_SLA_W);
                     end else begin
                        o.byte_to_send = {m_addr, 1'b1};
                        reload_wait(PH_SLA_R);
                     end
                  end
               end
               PH_SLA_W, PH_DATA_W: begin
                  ack_code = (m_phase == PH_SLA_W) ? ST_SLA_W_ACK : ST_DATA_W_ACK;
                  if (b.bus_status != ack_code) begin
                     stop_transfer(o, RC_ERROR);
                  end else if (m_tx_left != '0) begin
                     o.action       = ACT_LOAD;
                     o.byte_to_send = b.next_tx_byte;
                     m_tx_left      = m_tx_left - 1'b1;
                     reload_wait(PH_DATA_W);
                  end else if (m_rx_left != '0) begin
                     o.action = ACT_START;
                     reload_wait(PH_REP_START);
                  end else begin
                     finish_ok(o);
                  end
               end
               PH_REP_START: begin
                  if (b.bus_status != ST_REP_START) begin
                     stop_transfer(o, RC_ERROR);
                  end else begin
                     o.action       = ACT_LOAD;
                     o.byte_to_send = {m_addr, 1'b1};
                     reload_wait(PH_SLA_R);
                  end
               end
               PH_SLA_R: begin
                  if (b.bus_status != ST_SLA_R_ACK) begin
                     stop_transfer(o, RC_ERROR);
                  end else begin
                     o.action = (m_rx_left > 1) ? ACT_ACK : ACT_NACK;
                     reload_wait(PH_DATA_R);
                  end
               end
               PH_DATA_R: begin
                  // status is not looked at once read data flows
                  o.rx_valid = 1'b1;
                  o.rx_data  = b.received_byte;
                  if (m_rx_left != '0) m_rx_left = m_rx_left - 1'b1;
                  if (m_rx_left != '0) begin
                     o.action = (m_rx_left > 1) ? ACT_ACK : ACT_NACK;
                     reload_wait(PH_DATA_R);
                  end else begin
                     finish_ok(o);
                  end
               end
               default: m_phase = PH_IDLE;
            endcase
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         steps_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MASTER_ROLE:  m_master = csr_wdata[0];
               CSR_EVENT_ENABLE: m_events = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            cmd_beat.command       = req_mon.command;
            cmd_beat.slave_address = req_mon.slave_address;
            cmd_beat.write_length  = req_mon.write_length;
            cmd_beat.read_length   = req_mon.read_length;
            cmd_beat.wait_limit    = req_mon.wait_limit;
            cmd_beat.bus_status    = req_mon.bus_status;
            cmd_beat.received_byte = req_mon.received_byte;
            cmd_beat.next_tx_byte  = req_mon.next_tx_byte;
            steps_due.push_back(sequence_step(cmd_beat));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.action           = rsp_mon.action;
            seen.byte_to_send     = rsp_mon.byte_to_send;
            seen.rx_valid         = rsp_mon.rx_valid;
            seen.rx_data          = rsp_mon.rx_data;
            seen.done_res         = rsp_mon.done_res;
            seen.result_code      = rsp_mon.result_code;
            seen.completion_event = rsp_mon.completion_event;
            results = results + 1;
            if (steps_due.size() == 0) begin
               errors = errors + 1;
               if (reported < 10) begin
                  reported = reported + 1;
                  $display("result beat %0d arrived with nothing outstanding: act=%0d", results,
                           seen.action);
               end
            end else begin
               want = steps_due.pop_front();
               if (seen.action !== want.action || seen.byte_to_send !== want.byte_to_send ||
                   seen.rx_valid !== want.rx_valid || seen.rx_data !== want.rx_data ||
                   seen.done_res !== want.done_res || seen.result_code !== want.result_code ||
                   seen.completion_event !== want.completion_event) begin
                  errors = errors + 1;
                  if (reported < 10) begin
                     reported = reported + 1;
                     $display("result beat %0d mismatch", results);
                     $display("  expected act=%0d byte=%02h rxv=%0d rx=%02h done=%0d code=%0d ev=%0d",
                              want.action, want.byte_to_send, want.rx_valid, want.rx_data,
                              want.done_res, want.result_code, want.completion_event);
                     $display("  actual   act=%0d byte=%02h rxv=%0d rx=%02h done=%0d code=%0d ev=%0d",
                              seen.action, seen.byte_to_send, seen.rx_valid, seen.rx_data,
                              seen.done_res, seen.result_code, seen.completion_event);
                  end
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= steps_due.size();
      checked    <= results;
   end

endmodule

/* bench/i2c_master_transfer_sequencer_tb.sv */
// top of the i2c transfer sequencer bench: clock, reset, csr writes, command beats and
// result back-pressure; depends on i2cms_pkg, both channel interfaces, the block and
// i2cms_sequence_monitor, which does the prediction and comparison
module i2c_master_transfer_sequencer_tb;
   import i2cms_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam int SEGMENTS     = 8;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [0:0] csr_index;
   logic [0:0] csr_wdata;

   i2cms_req_if req_bus ();
   i2cms_rsp_if rsp_bus ();

   int   fail_count;
   int   pending;
   int   checked;
   int   cycle_count = 0;
   int   src_pct = 0;
   int   dst_pct = 0;
   int   work_beats = 0;
   int   transfers = 0;
   int   wait_budget = 65535;
   logic role_now = 1'b1;

   // per segment: role, event enable, sender idle %, receiver stall %, beats
   logic seg_role   [SEGMENTS] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
   logic seg_events [SEGMENTS] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
   int   seg_src    [SEGMENTS] = '{0, 70, 0, 0, 18, 18, 70, 18};
   int   seg_dst    [SEGMENTS] = '{0, 0, 70, 70, 18, 18, 0, 18};
   int   seg_beats  [SEGMENTS] = '{300, 250, 40, 300, 250, 40, 260, 260};

   i2c_master_transfer_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   i2cms_sequence_monitor i_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at cycle limit with %0d results outstanding", pending);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= (dst_pct == 0) || ($urandom_range(0, 99) >= dst_pct);
   end

   function automatic req_type scrambled_beat();
      req_type r;
      r.command       = 2'($urandom);
      r.slave_address = 7'($urandom);
      r.write_length  = 16'($urandom);
      r.read_length   = 16'($urandom);
      r.wait_limit    = $urandom;
      r.bus_status    = 8'($urandom);
      r.received_byte = 8'($urandom);
      r.next_tx_byte  = 8'($urandom);
      return r;
   endfunction

   function automatic req_type start_beat(input logic [6:0] addr, input logic [15:0] wl,
                                          input logic [15:0] rl, input logic [31:0] lim);
      req_type r;
      r               = scrambled_beat();
      r.command       = CMD_START;
      r.slave_address = addr;
      r.write_length  = wl;
      r.read_length   = rl;
      r.wait_limit    = lim;
      return r;
   endfunction

   function automatic req_type irq_beat(input logic [7:0] status, input logic [7:0] rxb,
                                        input logic [7:0] txb);
      req_type r;
      r               = scrambled_beat();
      r.command       = CMD_IRQ;
      r.bus_status    = status;
      r.received_byte = rxb;
      r.next_tx_byte  = txb;
      return r;
   endfunction

   function automatic req_type tick_beat();
      req_type r;
      r         = scrambled_beat();
      r.command = CMD_TICK;
      return r;
   endfunction

   task automatic drive_fields(input req_type b);
      req_bus.command       <= b.command;
      req_bus.slave_address <= b.slave_address;
      req_bus.write_length  <= b.write_length;
      req_bus.read_length   <= b.read_length;
      req_bus.wait_limit    <= b.wait_limit;
      req_bus.bus_status    <= b.bus_status;
      req_bus.received_byte <= b.received_byte;
      req_bus.next_tx_byte  <= b.next_tx_byte;
   endtask

   task automatic send_beat(input req_type b, input bit counts);
      while (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      drive_fields(b);
      do @(posedge clock); while (!req_bus.ready);
      if (counts) work_beats = work_beats + 1;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(tick_beat(), 1'b1);
   endtask

   // hold the sender off until every result beat is back
   task automatic wait_all_done();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_config(input logic role, input logic ev);
      csr_we    <= 1'b1;
      csr_index <= CSR_MASTER_ROLE;
      csr_wdata <= role;
      @(posedge clock);
      csr_index <= CSR_EVENT_ENABLE;
      csr_wdata <= ev;
      @(posedge clock);
      csr_we   <= 1'b0;
      role_now  = role;
   endtask

   // one controller wait: now and then a stray start, a few ticks, then the interrupt, unless this wait is made to fail
   task automatic wait_step(input logic [7:0] status, input bit status_checked,
                            input bit force_abort, inout bit ended);
      int         ticks;
      logic [7:0] bad;
      if (ended) return;
      if ($urandom_range(0, 99) < 3) begin
         send_beat(start_beat(7'($urandom), 16'($urandom), 16'($urandom), $urandom), 1'b1);
      end
      if ((force_abort || $urandom_range(0, 99) < 4) && wait_budget <= 8 &&
          (!status_checked || $urandom_range(0, 1) == 0)) begin
         send_ticks(wait_budget);
         ended = 1'b1;
         return;
      end
      if ((force_abort || $urandom_range(0, 99) < 4) && status_checked) begin
         bad = 8'($urandom);
         if (bad == status) bad = bad ^ 8'h01;
         send_beat(irq_beat(bad, 8'($urandom), 8'($urandom)), 1'b1);
         ended = 1'b1;
         return;
      end
      ticks = $urandom_range(0, (wait_budget > 2) ? 2 : wait_budget - 1);
      send_ticks(ticks);
      send_beat(irq_beat(status, 8'($urandom), 8'($urandom)), 1'b1);
   endtask

   task automatic run_transfer();
      logic [6:0]  addr;
      logic [15:0] wl;
      logic [15:0] rl;
      logic [31:0] lim;
      bit          huge;
      bit          ended;
      int          cap;
      int          i;
      int          pick;
      addr = 7'($urandom);
      pick = $urandom_range(0, 99);
      huge = (pick < 6);
      cap  = 0;
      if (huge) begin
         wl  = 16'($urandom);
         rl  = 16'($urandom);
         lim = $urandom_range(1, 8);
         cap = $urandom_range(1, 6);
      end else begin
         wl = 16'($urandom_range(0, 4));
         rl = 16'($urandom_range(0, 4));
         if (wl == 0 && rl == 0 && $urandom_range(0, 1) == 1) rl = 16'd1;
         pick = $urandom_range(0, 9);
         if (pick == 0) lim = '0;
         else if (pick == 1) lim = $urandom;
         else lim = $urandom_range(1, 8);
      end
      wait_budget = (lim == 0) ? 65535 : ((lim > 65535) ? 65535 : int'(lim));
      transfers   = transfers + 1;
      send_beat(start_beat(addr, wl, rl, lim), 1'b1);
      if (!role_now || (wl == 0 && rl == 0)) return;
      ended = 1'b0;
      wait_step(ST_START, 1'b1, 1'b0, ended);
      if (wl != 0) begin
         wait_step(ST_SLA_W_ACK, 1'b1, 1'b0, ended);
         i = 0;
         while (!ended && i < wl) begin
            wait_step(ST_DATA_W_ACK, 1'b1, huge && i >= cap, ended);
            i = i + 1;
         end
      end
      if (rl != 0) begin
         if (wl != 0) wait_step(ST_REP_START, 1'b1, 1'b0, ended);
         wait_step(ST_SLA_R_ACK, 1'b1, 1'b0, ended);
         i = 0;
         while (!ended && i < rl) begin
            wait_step(8'($urandom), 1'b0, huge && i >= cap, ended);
            i = i + 1;
         end
      end
   endtask

   // events while idle, plus now and then a start that, if accepted, the next interrupt kills
   task automatic send_noise();
      req_type b;
      int      n;
      logic [7:0] bad;
      n = $urandom_range(1, 4);
      repeat (n) begin
         b         = scrambled_beat();
         b.command = 2'($urandom_range(1, 3));
         send_beat(b, 1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
         send_beat(start_beat(7'($urandom), 16'($urandom), 16'($urandom), $urandom), 1'b1);
         bad = 8'($urandom);
         if (bad == ST_START) bad = bad ^ 8'h01;
         send_beat(irq_beat(bad, 8'($urandom), 8'($urandom)), 1'b1);
      end
   endtask

   initial begin
      int target;
      reset = 1'b1;
      csr_we    <= 1'b0;
      csr_index <= CSR_MASTER_ROLE;
      csr_wdata <= 1'b0;
      req_bus.valid <= 1'b0;
      drive_fields('0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: idle events, refused starts, a full write-then-read, read only,
      // timeouts in the start and read-address waits, extreme lengths and limits
      send_beat(irq_beat(ST_START, 8'hFF, 8'hFF), 1'b0);
      send_beat(tick_beat(), 1'b0);
      send_beat(start_beat(7'h7F, 16'd0, 16'd0, 32'd0), 1'b1);
      send_beat(start_beat(7'h7F, 16'd1, 16'd2, 32'd0), 1'b1);
      send_beat(irq_beat(ST_START, 8'h00, 8'h00), 1'b1);
      send_beat(irq_beat(ST_SLA_W_ACK, 8'h00, 8'hFF), 1'b1);
      send_beat(irq_beat(ST_DATA_W_ACK, 8'h00, 8'h00), 1'b1);
      send_beat(start_beat(7'h00, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1);
      send_beat(irq_beat(ST_REP_START, 8'h00, 8'h00), 1'b1);
      send_beat(irq_beat(ST_SLA_R_ACK, 8'h00, 8'h00), 1'b1);
      send_beat(irq_beat(8'hFF, 8'h00, 8'h00), 1'b1);
      send_beat(irq_beat(8'h00, 8'hFF, 8'h00), 1'b1);
      send_beat(start_beat(7'h00, 16'd0, 16'd1, 32'd1), 1'b1);
      send_beat(irq_beat(ST_START, 8'h00, 8'h00), 1'b1);
      send_ticks(1);
      send_beat(start_beat(7'h00, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1);
      send_ticks(1);
      send_beat(irq_beat(8'h00, 8'h00, 8'h00), 1'b1);
      send_beat(start_beat(7'h55, 16'd1, 16'd0, 32'd2), 1'b1);
      send_ticks(2);
      wait_all_done();
      set_config(1'b0, 1'b1);
      send_beat(start_beat(7'h2A, 16'd3, 16'd3, 32'd5), 1'b1);

      for (int s = 0; s < SEGMENTS; s++) begin
         wait_all_done();
         set_config(seg_role[s], seg_events[s]);
         src_pct = seg_src[s];
         dst_pct = seg_dst[s];
         target  = work_beats + seg_beats[s];
         while (work_beats < target) begin
            if ($urandom_range(0, 99) < 15) send_noise();
            else run_transfer();
         end
      end

      wait_all_done();
      dst_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d transfers, %0d working beats, %0d results compared", transfers,
               work_beats, checked);
      $display("over %0d csr settings and idle/stall mixes", SEGMENTS + 1);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
